// ===== src/dtb_pkg.sv =====
// dtb_pkg: shared constants, codes and types of the dominator tree builder
// no dependencies; imported by every module of the block but dtb_ram

package dtb_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int MAX_EDGES  = 4096;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int EADDR_W    = $clog2(MAX_EDGES);
  localparam int ECNT_W     = $clog2(MAX_EDGES + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_START_NODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd1;

  typedef enum logic [1:0] {
    REQ_CLEAR,
    REQ_ADD,
    REQ_COMPUTE,
    REQ_QUERY
  } req_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_RANGE,
    ST_STALE
  } status_e;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
  } edge_t;

  typedef struct packed {
    logic              visited;
    logic [NODE_W-1:0] num;
  } node_ent_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_RESULT,
    OP_FAIL,
    OP_CLEAR_EDGES,
    OP_ADD_EDGE,
    OP_CLR_START,
    OP_CLR_NODE,
    OP_SEED,
    OP_BFS_RD_U,
    OP_BFS_GOT_U,
    OP_EDGE_RD,
    OP_EDGE_SKIP,
    OP_BFS_NEXT_NODE,
    OP_BFS_TGT_RD,
    OP_BFS_VISIT,
    OP_PASS_START,
    OP_PASS_SRC_RD,
    OP_PASS_DST_RD,
    OP_PASS_CUR_RD,
    OP_PASS_CUR,
    OP_PASS_CLIMB,
    OP_PASS_STEPGOT,
    OP_PASS_UPDATE,
    OP_FINISH,
    OP_Q_NODE_RD,
    OP_Q_EARLY,
    OP_Q_IDOM_RD,
    OP_Q_ORDER_RD,
    OP_Q_DONE,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    req_e req;
    logic add_bad;
    logic edge_full;
    logic root_bad;
    logic computed;
    logic q_bad;
    logic clr_last;
    logic bfs_empty;
    logic edges_done;
    logic edge_ok;
    logic bfs_match;
    logic node_visited;
    logic node_is_root;
    logic fingers_eq;
    logic cur_same;
    logic changed;
    logic q_is_start;
  } dp_sts_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_CLR,
    S_SEED,
    S_BFS_NEXT,
    S_BFS_U,
    S_BFS_EDGE,
    S_BFS_CHK,
    S_BFS_TGT,
    S_PASS_EDGE,
    S_PASS_CHK,
    S_PASS_SRC,
    S_PASS_DST,
    S_PASS_CUR,
    S_PASS_WALK,
    S_PASS_STEP,
    S_Q_IDOM,
    S_Q_ORDER,
    S_Q_RES,
    S_DONE
  } ctrl_state_e;

endpackage

// ===== src/dtb_ram.sv =====
// dtb_ram: generic single-write, single-read memory with registered read data
// no dependencies

module dtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dtb_datapath.sv =====
// dtb_datapath: edge store, node tables, counters and result registers
// depends on dtb_pkg and dtb_ram; driven by dtb_ctrl commands

module dtb_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dtb_pkg::dp_cmd_t               cmd_i,
  output dtb_pkg::dp_sts_t               sts_o,
  input  logic [1:0]                     req_type_i,
  input  logic [dtb_pkg::NODE_W-1:0]     node_a_i,
  input  logic [dtb_pkg::NODE_W-1:0]     node_b_i,
  input  logic                           cfg_we_i,
  input  logic [dtb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dtb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [1:0]                     status_o,
  output logic [dtb_pkg::NODE_W-1:0]     dominator_node_o,
  output logic                           has_dominator_o,
  output logic                           is_reachable_o
);
  import dtb_pkg::*;

  req_e              req_q, req_d;
  logic [NODE_W-1:0] a_q, a_d, b_q, b_d, start_q, start_d;
  logic [CNT_W-1:0]  ncount_q, ncount_d, n_eff;
  logic [ECNT_W-1:0] etotal_q, etotal_d, eidx_q, eidx_d;
  logic              computed_q, computed_d, changed_q, changed_d, side_q, side_d;
  logic [NODE_W-1:0] ctr_q, ctr_d, u_q, u_d, edst_q, edst_d;
  logic [CNT_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [NODE_W-1:0] f1_q, f1_d, f2_q, f2_d, cur_q, cur_d, bnum_q, bnum_d;
  status_e           res_status_q, res_status_d, out_status_q, out_status_d;
  logic [NODE_W-1:0] res_dom_q, res_dom_d, out_dom_q, out_dom_d;
  logic              res_has_q, res_has_d, out_has_q, out_has_d;
  logic              res_reach_q, res_reach_d, out_reach_q, out_reach_d;

  // memory ports
  logic                   e_we, e_re, n_we, n_re, o_we, o_re, i_we, i_re;
  logic [EADDR_W-1:0]     e_waddr, e_raddr;
  logic [NODE_W-1:0]      n_waddr, n_raddr, o_waddr, o_raddr, i_waddr, i_raddr;
  logic [2*NODE_W-1:0]    e_wdata, e_rdata;
  logic [NODE_W:0]        n_wdata, n_rdata;
  logic [NODE_W-1:0]      o_wdata, o_rdata, i_wdata, i_rdata;
  edge_t                  edge_rd;
  node_ent_t              node_rd;

  assign edge_rd = edge_t'(e_rdata);
  assign node_rd = node_ent_t'(n_rdata);
  assign n_eff   = (ncount_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : ncount_q;

  // edge store, node info by id, visit order by number, dominator number by number
  dtb_ram #(.WIDTH(2 * NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .re_i(e_re), .raddr_i(e_raddr), .rdata_o(e_rdata)
  );
  dtb_ram #(.WIDTH(NODE_W + 1), .DEPTH(MAX_NODES)) u_node_ram (
    .clk_i, .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .re_i(n_re), .raddr_i(n_raddr), .rdata_o(n_rdata)
  );
  dtb_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_order_ram (
    .clk_i, .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .re_i(o_re), .raddr_i(o_raddr), .rdata_o(o_rdata)
  );
  dtb_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_idom_ram (
    .clk_i, .we_i(i_we), .waddr_i(i_waddr), .wdata_i(i_wdata),
    .re_i(i_re), .raddr_i(i_raddr), .rdata_o(i_rdata)
  );

  always_comb begin
    sts_o.req          = req_q;
    sts_o.add_bad      = (CNT_W'(a_q) >= n_eff) || (CNT_W'(b_q) >= n_eff);
    sts_o.edge_full    = etotal_q >= ECNT_W'(MAX_EDGES);
    sts_o.root_bad     = CNT_W'(start_q) >= n_eff;
    sts_o.computed     = computed_q;
    sts_o.q_bad        = CNT_W'(a_q) >= n_eff;
    sts_o.clr_last     = ctr_q == NODE_W'(MAX_NODES - 1);
    sts_o.bfs_empty    = head_q == tail_q;
    sts_o.edges_done   = eidx_q == etotal_q;
    sts_o.edge_ok      = (CNT_W'(edge_rd.src) < n_eff) && (CNT_W'(edge_rd.dst) < n_eff);
    sts_o.bfs_match    = sts_o.edge_ok && (edge_rd.src == u_q);
    sts_o.node_visited = node_rd.visited;
    sts_o.node_is_root = node_rd.num == '0;
    sts_o.fingers_eq   = f1_q == f2_q;
    sts_o.cur_same     = f1_q == cur_q;
    sts_o.changed      = changed_q;
    sts_o.q_is_start   = a_q == start_q;
  end

  always_comb begin
    req_d = req_q;  a_d = a_q;  b_d = b_q;
    start_d = start_q;  ncount_d = ncount_q;
    etotal_d = etotal_q;  eidx_d = eidx_q;
    computed_d = computed_q;  changed_d = changed_q;  side_d = side_q;
    ctr_d = ctr_q;  u_d = u_q;  edst_d = edst_q;
    head_d = head_q;  tail_d = tail_q;
    f1_d = f1_q;  f2_d = f2_q;  cur_d = cur_q;  bnum_d = bnum_q;
    res_status_d = res_status_q;  res_dom_d = res_dom_q;
    res_has_d = res_has_q;  res_reach_d = res_reach_q;
    out_status_d = out_status_q;  out_dom_d = out_dom_q;
    out_has_d = out_has_q;  out_reach_d = out_reach_q;
    e_we = 1'b0;  e_re = 1'b0;  e_waddr = '0;  e_raddr = '0;  e_wdata = '0;
    n_we = 1'b0;  n_re = 1'b0;  n_waddr = '0;  n_raddr = '0;  n_wdata = '0;
    o_we = 1'b0;  o_re = 1'b0;  o_waddr = '0;  o_raddr = '0;  o_wdata = '0;
    i_we = 1'b0;  i_re = 1'b0;  i_waddr = '0;  i_raddr = '0;  i_wdata = '0;

    // register writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we_i) begin
      computed_d = 1'b0;
      case (cfg_idx_i)
        CFG_START_NODE: start_d  = cfg_data_i[NODE_W-1:0];
        CFG_NODE_COUNT: ncount_d = cfg_data_i[CNT_W-1:0];
        default:        computed_d = computed_q;
      endcase
    end

    case (cmd_i.op)
      OP_LATCH: begin
        req_d = req_e'(req_type_i);
        a_d   = node_a_i;
        b_d   = node_b_i;
      end
      OP_RESULT, OP_FAIL: begin
        res_status_d = cmd_i.code;
        res_dom_d = '0;  res_has_d = 1'b0;  res_reach_d = 1'b0;
        if (cmd_i.op == OP_FAIL) begin
          computed_d = 1'b0;
        end
      end
      OP_CLEAR_EDGES: begin
        etotal_d = '0;  computed_d = 1'b0;
        res_status_d = ST_OK;
        res_dom_d = '0;  res_has_d = 1'b0;  res_reach_d = 1'b0;
      end
      OP_ADD_EDGE: begin
        e_we = 1'b1;
        e_waddr = etotal_q[EADDR_W-1:0];
        e_wdata = {a_q, b_q};
        etotal_d = etotal_q + ECNT_W'(1);
        computed_d = 1'b0;
        res_status_d = ST_OK;
        res_dom_d = '0;  res_has_d = 1'b0;  res_reach_d = 1'b0;
      end
      OP_CLR_START: ctr_d = '0;
      OP_CLR_NODE: begin
        n_we = 1'b1;  n_waddr = ctr_q;  n_wdata = '0;
        ctr_d = ctr_q + NODE_W'(1);
      end
      OP_SEED: begin
        n_we = 1'b1;  n_waddr = start_q;  n_wdata = {1'b1, NODE_W'(0)};
        o_we = 1'b1;  o_waddr = '0;  o_wdata = start_q;
        i_we = 1'b1;  i_waddr = '0;  i_wdata = '0;
        head_d = '0;
        tail_d = CNT_W'(1);
      end
      OP_BFS_RD_U: begin
        o_re = 1'b1;  o_raddr = head_q[NODE_W-1:0];
      end
      OP_BFS_GOT_U: begin
        u_d = o_rdata;
        eidx_d = '0;
      end
      OP_EDGE_RD: begin
        e_re = 1'b1;  e_raddr = eidx_q[EADDR_W-1:0];
      end
      OP_EDGE_SKIP: eidx_d = eidx_q + ECNT_W'(1);
      OP_BFS_NEXT_NODE: head_d = head_q + CNT_W'(1);
      OP_BFS_TGT_RD: begin
        edst_d = edge_rd.dst;
        n_re = 1'b1;  n_raddr = edge_rd.dst;
      end
      OP_BFS_VISIT: begin
        n_we = 1'b1;  n_waddr = edst_q;  n_wdata = {1'b1, tail_q[NODE_W-1:0]};
        o_we = 1'b1;  o_waddr = tail_q[NODE_W-1:0];  o_wdata = edst_q;
        i_we = 1'b1;  i_waddr = tail_q[NODE_W-1:0];  i_wdata = head_q[NODE_W-1:0];
        tail_d = tail_q + CNT_W'(1);
        eidx_d = eidx_q + ECNT_W'(1);
      end
      OP_PASS_START: begin
        changed_d = 1'b0;
        eidx_d = '0;
      end
      OP_PASS_SRC_RD: begin
        edst_d = edge_rd.dst;
        n_re = 1'b1;  n_raddr = edge_rd.src;
      end
      OP_PASS_DST_RD: begin
        f2_d = node_rd.num;
        n_re = 1'b1;  n_raddr = edst_q;
      end
      OP_PASS_CUR_RD: begin
        bnum_d = node_rd.num;
        i_re = 1'b1;  i_raddr = node_rd.num;
      end
      OP_PASS_CUR: begin
        f1_d = i_rdata;
        cur_d = i_rdata;
      end
      OP_PASS_CLIMB: begin
        side_d = f1_q > f2_q;
        i_re = 1'b1;
        i_raddr = (f1_q > f2_q) ? f1_q : f2_q;
      end
      OP_PASS_STEPGOT: begin
        if (side_q) begin
          f1_d = i_rdata;
        end else begin
          f2_d = i_rdata;
        end
      end
      OP_PASS_UPDATE: begin
        i_we = 1'b1;  i_waddr = bnum_q;  i_wdata = f1_q;
        changed_d = 1'b1;
        eidx_d = eidx_q + ECNT_W'(1);
      end
      OP_FINISH: begin
        computed_d = 1'b1;
        res_status_d = ST_OK;
        res_dom_d = '0;  res_has_d = 1'b0;  res_reach_d = 1'b0;
      end
      OP_Q_NODE_RD: begin
        n_re = 1'b1;  n_raddr = a_q;
      end
      OP_Q_EARLY: begin
        res_status_d = ST_OK;
        res_dom_d = '0;  res_has_d = 1'b0;  res_reach_d = node_rd.visited;
      end
      OP_Q_IDOM_RD: begin
        i_re = 1'b1;  i_raddr = node_rd.num;
      end
      OP_Q_ORDER_RD: begin
        o_re = 1'b1;  o_raddr = i_rdata;
      end
      OP_Q_DONE: begin
        res_status_d = ST_OK;
        res_dom_d = o_rdata;  res_has_d = 1'b1;  res_reach_d = 1'b1;
      end
      OP_LOAD_OUT: begin
        out_status_d = res_status_q;  out_dom_d = res_dom_q;
        out_has_d = res_has_q;  out_reach_d = res_reach_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      ncount_q   <= CNT_W'(MAX_NODES);
      etotal_q   <= '0;
      computed_q <= 1'b0;
      eidx_q     <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      ctr_q      <= '0;
      changed_q  <= 1'b0;
    end else begin
      start_q    <= start_d;
      ncount_q   <= ncount_d;
      etotal_q   <= etotal_d;
      computed_q <= computed_d;
      eidx_q     <= eidx_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      ctr_q      <= ctr_d;
      changed_q  <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;  a_q <= a_d;  b_q <= b_d;
    side_q <= side_d;  u_q <= u_d;  edst_q <= edst_d;
    f1_q <= f1_d;  f2_q <= f2_d;  cur_q <= cur_d;  bnum_q <= bnum_d;
    res_status_q <= res_status_d;  res_dom_q <= res_dom_d;
    res_has_q <= res_has_d;  res_reach_q <= res_reach_d;
    out_status_q <= out_status_d;  out_dom_q <= out_dom_d;
    out_has_q <= out_has_d;  out_reach_q <= out_reach_d;
  end

  assign status_o         = 2'(out_status_q);
  assign dominator_node_o = out_dom_q;
  assign has_dominator_o  = out_has_q;
  assign is_reachable_o   = out_reach_q;

endmodule

// ===== src/dtb_ctrl.sv =====
// dtb_ctrl: sequencer state machine and handshake control
// depends on dtb_pkg; commands dtb_datapath, reads its status

module dtb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dtb_pkg::dp_sts_t sts_i,
  output dtb_pkg::dp_cmd_t cmd_o
);
  import dtb_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    cmd_o.code  = ST_OK;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (sts_i.req)
          REQ_CLEAR: cmd_o.op = OP_CLEAR_EDGES;
          REQ_ADD: begin
            if (sts_i.add_bad) begin
              cmd_o.op = OP_FAIL;  cmd_o.code = ST_RANGE;
            end else if (sts_i.edge_full) begin
              cmd_o.op = OP_FAIL;  cmd_o.code = ST_FULL;
            end else begin
              cmd_o.op = OP_ADD_EDGE;
            end
          end
          REQ_COMPUTE: begin
            if (sts_i.root_bad) begin
              cmd_o.op = OP_FAIL;  cmd_o.code = ST_RANGE;
            end else begin
              cmd_o.op = OP_CLR_START;
              state_d  = S_CLR;
            end
          end
          REQ_QUERY: begin
            if (!sts_i.computed) begin
              cmd_o.op = OP_RESULT;  cmd_o.code = ST_STALE;
            end else if (sts_i.q_bad) begin
              cmd_o.op = OP_RESULT;  cmd_o.code = ST_RANGE;
            end else begin
              cmd_o.op = OP_Q_NODE_RD;
              state_d  = S_Q_IDOM;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_CLR: begin
        cmd_o.op = OP_CLR_NODE;
        if (sts_i.clr_last) begin
          state_d = S_SEED;
        end
      end
      S_SEED: begin
        cmd_o.op = OP_SEED;
        state_d  = S_BFS_NEXT;
      end
      S_BFS_NEXT: begin
        if (sts_i.bfs_empty) begin
          cmd_o.op = OP_PASS_START;
          state_d  = S_PASS_EDGE;
        end else begin
          cmd_o.op = OP_BFS_RD_U;
          state_d  = S_BFS_U;
        end
      end
      S_BFS_U: begin
        cmd_o.op = OP_BFS_GOT_U;
        state_d  = S_BFS_EDGE;
      end
      S_BFS_EDGE: begin
        if (sts_i.edges_done) begin
          cmd_o.op = OP_BFS_NEXT_NODE;
          state_d  = S_BFS_NEXT;
        end else begin
          cmd_o.op = OP_EDGE_RD;
          state_d  = S_BFS_CHK;
        end
      end
      S_BFS_CHK: begin
        if (sts_i.bfs_match) begin
          cmd_o.op = OP_BFS_TGT_RD;
          state_d  = S_BFS_TGT;
        end else begin
          cmd_o.op = OP_EDGE_SKIP;
          state_d  = S_BFS_EDGE;
        end
      end
      S_BFS_TGT: begin
        cmd_o.op = sts_i.node_visited ? OP_EDGE_SKIP : OP_BFS_VISIT;
        state_d  = S_BFS_EDGE;
      end
      S_PASS_EDGE: begin
        if (sts_i.edges_done) begin
          if (sts_i.changed) begin
            cmd_o.op = OP_PASS_START;
          end else begin
            cmd_o.op = OP_FINISH;
            state_d  = S_DONE;
          end
        end else begin
          cmd_o.op = OP_EDGE_RD;
          state_d  = S_PASS_CHK;
        end
      end
      S_PASS_CHK: begin
        if (sts_i.edge_ok) begin
          cmd_o.op = OP_PASS_SRC_RD;
          state_d  = S_PASS_SRC;
        end else begin
          cmd_o.op = OP_EDGE_SKIP;
          state_d  = S_PASS_EDGE;
        end
      end
      S_PASS_SRC: begin
        if (sts_i.node_visited) begin
          cmd_o.op = OP_PASS_DST_RD;
          state_d  = S_PASS_DST;
        end else begin
          cmd_o.op = OP_EDGE_SKIP;
          state_d  = S_PASS_EDGE;
        end
      end
      S_PASS_DST: begin
        if (sts_i.node_is_root) begin
          cmd_o.op = OP_EDGE_SKIP;
          state_d  = S_PASS_EDGE;
        end else begin
          cmd_o.op = OP_PASS_CUR_RD;
          state_d  = S_PASS_CUR;
        end
      end
      S_PASS_CUR: begin
        cmd_o.op = OP_PASS_CUR;
        state_d  = S_PASS_WALK;
      end
      S_PASS_WALK: begin
        if (sts_i.fingers_eq) begin
          cmd_o.op = sts_i.cur_same ? OP_EDGE_SKIP : OP_PASS_UPDATE;
          state_d  = S_PASS_EDGE;
        end else begin
          cmd_o.op = OP_PASS_CLIMB;
          state_d  = S_PASS_STEP;
        end
      end
      S_PASS_STEP: begin
        cmd_o.op = OP_PASS_STEPGOT;
        state_d  = S_PASS_WALK;
      end
      S_Q_IDOM: begin
        if (sts_i.node_visited && !sts_i.q_is_start) begin
          cmd_o.op = OP_Q_IDOM_RD;
          state_d  = S_Q_ORDER;
        end else begin
          cmd_o.op = OP_Q_EARLY;
          state_d  = S_DONE;
        end
      end
      S_Q_ORDER: begin
        cmd_o.op = OP_Q_ORDER_RD;
        state_d  = S_Q_RES;
      end
      S_Q_RES: begin
        cmd_o.op = OP_Q_DONE;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/dominator_tree_builder.sv =====
// dominator_tree_builder: top level, joins the sequencer and the datapath
// depends on dtb_pkg, dtb_ctrl, dtb_datapath (and dtb_ram below it)
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid_i/in_ready_o, req_type_i,        | in
//          |   node_a_i, node_b_i                      |
//  result  | out_valid_o/out_ready_i, status_o,        | out
//          |   dominator_node_o, has_dominator_o,      |
//          |   is_reachable_o                          |
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i           | in
//
// clear, add edge and failing requests go from decode straight to the result; a query
//   reads the node, dominator and order tables in turn, through the single read port of each
// compute: clears every entry of the node table, then a breadth-first walk over the stored
//   edges for each reachable node, then repeated passes over all stored edges, each walking the
//   two finger chains, until no dominator changes
// reset (async, active low) empties the edge store and drops computed results
// one transaction in flight; a new request is taken while the last result
//   still waits, and the block stalls before its own result until that one leaves

module dominator_tree_builder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     req_type_i,
  input  logic [dtb_pkg::NODE_W-1:0]     node_a_i,
  input  logic [dtb_pkg::NODE_W-1:0]     node_b_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [dtb_pkg::NODE_W-1:0]     dominator_node_o,
  output logic                           has_dominator_o,
  output logic                           is_reachable_o,
  input  logic                           cfg_we_i,
  input  logic [dtb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dtb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dtb_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: request handling; compute does bfs numbering, then edge passes that intersect dominator chains
  // (walked by bfs number) until a whole pass leaves every entry unchanged
  dtb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // datapath: edge store, node/order/dominator memories, result registers
  dtb_datapath u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .req_type_i,
    .node_a_i,
    .node_b_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .status_o,
    .dominator_node_o,
    .has_dominator_o,
    .is_reachable_o
  );

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for dominator_tree_builder, with an internal
// dominator predictor (iterative dominator sets) and a queue-fed driver and monitor
// depends on dtb_pkg and the dominator_tree_builder rtl
`timescale 1ns / 100ps

module testbench;
  import dtb_pkg::*;

  localparam int LIMIT_CYCLES = 20000000;
  localparam int EDGE_SOFT_CAP = 48;

  typedef struct {
    req_e            req;
    bit [NODE_W-1:0] a;
    bit [NODE_W-1:0] b;
  } request_t;

  typedef struct {
    bit [1:0]        status;
    bit [NODE_W-1:0] dom;
    bit              has;
    bit              reach;
  } answer_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            req_type_i = '0;
  logic [NODE_W-1:0]     node_a_i = '0;
  logic [NODE_W-1:0]     node_b_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            status_o;
  logic [NODE_W-1:0]     dominator_node_o;
  logic                  has_dominator_o;
  logic                  is_reachable_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  dominator_tree_builder dut (.*);

  always #1 clk_i = ~clk_i;

  // pending requests and the answers the graph predictor expects, in order
  request_t request_q[$];
  answer_t  answer_q[$];
  int       mismatches = 0;
  int       cycles = 0;
  bit       calm = 1'b0;   // phase with no idling on either side

  // predictor copy of the block state
  bit [NODE_W-1:0]    edge_src[MAX_EDGES];
  bit [NODE_W-1:0]    edge_dst[MAX_EDGES];
  int                 edge_cnt;
  bit                 graph_ready;
  bit [NODE_W-1:0]    root_node;
  bit [CFG_DATA_W-1:0] node_lim;
  bit                 reached[MAX_NODES];
  bit [NODE_W-1:0]    idom_of[MAX_NODES];
  bit [MAX_NODES-1:0] dom_set[MAX_NODES];

  function automatic int live_nodes();
    return node_lim > MAX_NODES ? MAX_NODES : int'(node_lim);
  endfunction

  // reachability by breadth-first walk, then dominator sets to a fixpoint;
  // the immediate dominator is the strict dominator with the largest set
  function automatic void solve_dominators();
    int n, v, s, d, best, best_cnt, c;
    int order[$];
    int work[$];
    bit changed;
    bit [MAX_NODES-1:0] acc;
    n = live_nodes();
    foreach (reached[i]) reached[i] = 1'b0;
    reached[root_node] = 1'b1;
    order.insert(order.size(), int'(root_node));
    work.insert(work.size(), int'(root_node));
    while (work.size() > 0) begin
      v = work.pop_front();
      for (int e = 0; e < edge_cnt; e++) begin
        if (edge_src[e] == v && edge_dst[e] < n && !reached[edge_dst[e]]) begin
          reached[edge_dst[e]] = 1'b1;
          order.insert(order.size(), int'(edge_dst[e]));
          work.insert(work.size(), int'(edge_dst[e]));
        end
      end
    end
    foreach (order[i]) begin
      dom_set[order[i]] = '1;
      if (order[i] == root_node) begin
        dom_set[order[i]] = '0;
        dom_set[order[i]][root_node] = 1'b1;
      end
    end
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      foreach (order[i]) begin
        v = order[i];
        if (v == root_node) continue;
        acc = '1;
        for (int e = 0; e < edge_cnt; e++) begin
          s = edge_src[e];
          if (edge_dst[e] == v && s < n && reached[s]) acc &= dom_set[s];
        end
        acc[v] = 1'b1;
        if (acc != dom_set[v]) begin
          dom_set[v] = acc;
          changed = 1'b1;
        end
      end
    end
    foreach (order[i]) begin
      v = order[i];
      best = 0;
      best_cnt = -1;
      foreach (order[j]) begin
        d = order[j];
        if (d != v && dom_set[v][d]) begin
          c = $countones(dom_set[d]);
          if (c > best_cnt) begin
            best_cnt = c;
            best = d;
          end
        end
      end
      idom_of[v] = best[NODE_W-1:0];
    end
  endfunction

  // one accepted request: update predictor state and queue its answer
  function automatic void apply_request(request_t r);
    answer_t ans;
    int n;
    ans = '{status: ST_OK, dom: '0, has: 1'b0, reach: 1'b0};
    n = live_nodes();
    case (r.req)
      REQ_CLEAR: begin
        edge_cnt = 0;
        graph_ready = 1'b0;
      end
      REQ_ADD: begin
        graph_ready = 1'b0;
        if (r.a >= n || r.b >= n) ans.status = ST_RANGE;
        else if (edge_cnt >= MAX_EDGES) ans.status = ST_FULL;
        else begin
          edge_src[edge_cnt] = r.a;
          edge_dst[edge_cnt] = r.b;
          edge_cnt++;
        end
      end
      REQ_COMPUTE: begin
        if (root_node >= n) begin
          ans.status = ST_RANGE;
          graph_ready = 1'b0;
        end else begin
          solve_dominators();
          graph_ready = 1'b1;
        end
      end
      default: begin
        if (!graph_ready) ans.status = ST_STALE;
        else if (r.a >= n) ans.status = ST_RANGE;
        else begin
          ans.reach = reached[r.a];
          if (reached[r.a] && r.a != root_node) begin
            ans.has = 1'b1;
            ans.dom = idom_of[r.a];
          end
        end
      end
    endcase
    answer_q.insert(answer_q.size(), ans);
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 19);
    if (p < 12) return 0;
    if (p < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: one request at a time, random gaps between transactions
  request_t cur;
  int       in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && in_ready_o) apply_request(cur);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur = request_q.pop_front();
          req_type_i <= cur.req;
          node_a_i   <= cur.a;
          node_b_i   <= cur.b;
          in_valid_i <= 1'b1;
          in_gap     <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest answer
  int out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result status=%0d", status_o);
        end else begin
          w = answer_q.pop_front();
          if (status_o !== w.status || dominator_node_o !== w.dom ||
              has_dominator_o !== w.has || is_reachable_o !== w.reach) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want st=%0d dom=%0d has=%0d reach=%0d, got %0d %0d %0d %0d",
                       w.status, w.dom, w.has, w.reach, status_o, dominator_node_o,
                       has_dominator_o, is_reachable_o);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap     <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap     <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push(req_e r, int a, int b);
    request_t t;
    t.req = r;
    t.a = a[NODE_W-1:0];
    t.b = b[NODE_W-1:0];
    request_q.insert(request_q.size(), t);
  endtask

  task automatic drain();
    while (request_q.size() > 0 || answer_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // register write, only called with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_START_NODE) root_node = val[NODE_W-1:0];
    else node_lim = val[CFG_DATA_W-1:0];
    graph_ready = 1'b0;
  endtask

  function automatic int any_node(int n);
    if (n == 0 || $urandom_range(0, 15) == 0) return $urandom_range(0, MAX_NODES - 1);
    return $urandom_range(0, n - 1);
  endfunction

  // random phase: mostly well-formed graphs, a compute, then queries
  task automatic random_phase(int n);
    int k;
    if (edge_cnt > EDGE_SOFT_CAP || $urandom_range(0, 2) == 0) push(REQ_CLEAR, 0, 0);
    repeat (3) begin
      k = $urandom_range(2, 14);
      repeat (k) push(REQ_ADD, any_node(n), any_node(n));
      push(REQ_COMPUTE, $urandom, $urandom);
      repeat ($urandom_range(8, 24)) begin
        case ($urandom_range(0, 19))
          0:       push(REQ_ADD, any_node(n), any_node(n));
          1:       push(REQ_COMPUTE, $urandom, $urandom);
          default: push(REQ_QUERY, any_node(n), $urandom);
        endcase
      end
      if (edge_cnt + 20 > EDGE_SOFT_CAP) push(REQ_CLEAR, 0, 0);
    end
  endtask

  initial begin
    int n;
    edge_cnt    = 0;
    graph_ready = 1'b0;
    root_node   = '0;
    node_lim    = MAX_NODES;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers: stale query, empty graph, a diamond, self loop, top node
    push(REQ_QUERY, 0, 0);
    push(REQ_COMPUTE, 0, 0);
    push(REQ_QUERY, 0, 0);
    push(REQ_QUERY, 1023, 0);
    push(REQ_ADD, 0, 1);
    push(REQ_ADD, 0, 2);
    push(REQ_ADD, 1, 3);
    push(REQ_ADD, 2, 3);
    push(REQ_ADD, 3, 1023);
    push(REQ_ADD, 1023, 1023);
    push(REQ_ADD, 0, 1);
    push(REQ_COMPUTE, 0, 0);
    for (int i = 0; i < 4; i++) push(REQ_QUERY, i, 0);
    push(REQ_QUERY, 1023, 1023);
    push(REQ_CLEAR, 0, 0);
    push(REQ_QUERY, 3, 0);

    // small graph with top root, an out of range end and an out of range root
    write_reg(CFG_NODE_COUNT, 4);
    write_reg(CFG_START_NODE, 3);
    push(REQ_ADD, 5, 1);
    push(REQ_ADD, 3, 2);
    push(REQ_ADD, 2, 0);
    push(REQ_COMPUTE, 0, 0);
    push(REQ_QUERY, 0, 0);
    push(REQ_QUERY, 7, 0);
    write_reg(CFG_START_NODE, 1023);
    push(REQ_COMPUTE, 0, 0);
    push(REQ_QUERY, 0, 0);

    // zero and oversized node counts
    write_reg(CFG_NODE_COUNT, 0);
    write_reg(CFG_START_NODE, 0);
    push(REQ_ADD, 0, 0);
    push(REQ_COMPUTE, 0, 0);
    write_reg(CFG_NODE_COUNT, 2047);
    push(REQ_COMPUTE, 0, 0);
    push(REQ_QUERY, 3, 0);
    push(REQ_QUERY, 1023, 0);

    // random graphs under a range of register settings
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 5))
        0:       n = MAX_NODES;
        1:       n = $urandom_range(MAX_NODES + 1, 2047);
        2:       n = $urandom_range(1, 3);
        default: n = $urandom_range(4, 24);
      endcase
      write_reg(CFG_NODE_COUNT, n);
      if (n > MAX_NODES) n = MAX_NODES;
      write_reg(CFG_START_NODE, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, n - 1));
      calm = ($urandom_range(0, 3) == 0);
      random_phase(n);
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dtb_pkg.sv
src/dtb_ram.sv
src/dtb_datapath.sv
src/dtb_ctrl.sv
src/dominator_tree_builder.sv
verif/testbench.sv
